/* hdl/ffs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffs_pkg
// Shared widths, register indexes and types of the flicker frame sequencer.
// ----------------------------------------------------------------------------
package ffs_pkg;

    // default width of the random draw fraction
    localparam int DRAW_BITS_DEF = 16;

    // fixed field widths
    localparam int REFRESH_W = 8;
    localparam int FLICKER_W = 7;
    localparam int FRAMES_W  = 8;
    localparam int CFG_W     = 8;

    // divider steps, one quotient bit per cycle
    localparam int DIV_STEPS = REFRESH_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration register indexes
    typedef enum logic {
        REG_REFRESH_RATE = 1'b0,
        REG_FLICKER_RATE = 1'b1
    } ffs_reg_idx_t;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } ffs_div_status_t;

endpackage

/* hdl/ffs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffs_div
// Restoring divider of the refresh rate by the flicker rate, one quotient
// bit per cycle, giving frames per period and the count of long periods.
// ----------------------------------------------------------------------------
module ffs_div
    import ffs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [REFRESH_W-1:0] dividend,
    input  logic [FLICKER_W-1:0] divisor,
    output logic [REFRESH_W-1:0] quotient,
    output logic [FLICKER_W-1:0] remainder,
    output ffs_div_status_t      status
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [FLICKER_W-1:0] rem_reg;
    logic [FLICKER_W-1:0] rem_next;
    logic [REFRESH_W-1:0] quo_reg;
    logic [REFRESH_W-1:0] quo_next;

    logic [FLICKER_W:0]   trial;
    logic [FLICKER_W:0]   diff;
    logic                 fits;

    // one trial subtraction per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[REFRESH_W-1]};
        fits  = trial >= {1'b0, divisor};
        diff  = trial - {1'b0, divisor};
    end

    // step control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? diff[FLICKER_W-1:0] : trial[FLICKER_W-1:0];
            quo_next = {quo_reg[REFRESH_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* hdl/flicker_frame_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flicker_frame_sequencer
// Gives one second of square-wave flicker periods as frame count pairs.
// ----------------------------------------------------------------------------
// Each input word asks for the next flicker period and returns one result
// word. A word that does not reload passes the draw multiply, pick and output
// register states before the next input word is taken. A reload (restart
// set, or the second used up) runs the shared restoring divider over the 8
// bits of the refresh rate, one bit per cycle, before the multiply; a reload
// that ends in the rate error or the steady case goes straight to output.
// The input is not ready while a word is being worked on; a finished word
// waits in the output register while the next input word is taken.
// Register writes take effect at the next reload.
// ----------------------------------------------------------------------------
module flicker_frame_sequencer
    import ffs_pkg::*;
#(
    parameter int DRAW_BITS = DRAW_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,
    input  logic [DRAW_BITS-1:0] s_draw,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAMES_W-1:0]  m_first_half_frames,
    output logic [FRAMES_W-1:0]  m_second_half_frames,
    output logic                 m_last,
    output logic                 m_rate_error
);

    localparam int PROD_W = DRAW_BITS + FLICKER_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_PICK = 5'b01000,
        ST_OUT  = 5'b10000
    } ffs_state_t;

    ffs_state_t           state_reg;
    ffs_state_t           state_next;

    logic [REFRESH_W-1:0] refresh_reg;
    logic [FLICKER_W-1:0] flicker_reg;

    logic [FLICKER_W-1:0] long_left_reg;
    logic [FLICKER_W-1:0] long_left_next;
    logic [FLICKER_W-1:0] short_left_reg;
    logic [FLICKER_W-1:0] short_left_next;
    logic [FLICKER_W-1:0] long_total_reg;
    logic [FLICKER_W-1:0] long_total_next;
    logic [FLICKER_W-1:0] short_total_reg;
    logic [FLICKER_W-1:0] short_total_next;
    logic [FRAMES_W-1:0]  base_frames_reg;
    logic [FRAMES_W-1:0]  base_frames_next;

    logic [DRAW_BITS-1:0] draw_reg;
    logic [DRAW_BITS-1:0] draw_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;

    logic [FRAMES_W-1:0]  res_first_reg;
    logic [FRAMES_W-1:0]  res_first_next;
    logic [FRAMES_W-1:0]  res_second_reg;
    logic [FRAMES_W-1:0]  res_second_next;
    logic                 res_last_reg;
    logic                 res_last_next;
    logic                 res_err_reg;
    logic                 res_err_next;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [FRAMES_W-1:0]  m_first_reg;
    logic [FRAMES_W-1:0]  m_second_reg;
    logic                 m_last_reg;
    logic                 m_err_reg;

    logic                 accept;
    logic                 reload;
    logic                 too_high;
    logic                 out_free;
    logic                 div_start;
    logic [REFRESH_W-1:0] div_quo;
    logic [FLICKER_W-1:0] div_rem;
    ffs_div_status_t      div_status;

    logic [FLICKER_W-1:0] rate;
    logic                 draw_long;
    logic                 take_long;
    logic [FRAMES_W-1:0]  half_lo;
    logic [FRAMES_W-1:0]  half_hi;
    logic [FLICKER_W-1:0] k_long;
    logic [FLICKER_W-1:0] k_short;

    // shared divider
    ffs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (refresh_reg),
        .divisor   (flicker_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .status    (div_status)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refresh_reg <= REFRESH_W'(60);
            flicker_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (ffs_reg_idx_t'(cfg_index))
                REG_REFRESH_RATE: refresh_reg <= cfg_wdata[REFRESH_W-1:0];
                REG_FLICKER_RATE: flicker_reg <= cfg_wdata[FLICKER_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake and reload decision
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign reload    = s_restart || (long_left_reg == '0 && short_left_reg == '0);
    assign too_high  = {flicker_reg, 1'b0} > {1'b0, refresh_reg};
    assign div_start = accept && reload && !too_high && (flicker_reg != '0);

    // period choice and half split
    always_comb begin
        rate      = long_total_reg + short_total_reg;
        draw_long = prod_reg[DRAW_BITS +: FLICKER_W] < long_total_reg;
        take_long = (long_left_reg != '0) && ((short_left_reg == '0) || draw_long);
        k_long    = long_left_reg - 1'b1;
        k_short   = short_left_reg - 1'b1;
        half_lo   = base_frames_reg >> 1;
        half_hi   = half_lo + 1'b1;
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        long_left_next   = long_left_reg;
        short_left_next  = short_left_reg;
        long_total_next  = long_total_reg;
        short_total_next = short_total_reg;
        base_frames_next = base_frames_reg;
        draw_next        = draw_reg;
        prod_next        = prod_reg;
        res_first_next   = res_first_reg;
        res_second_next  = res_second_reg;
        res_last_next    = res_last_reg;
        res_err_next     = res_err_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    draw_next = s_draw;
                    if (reload) begin
                        long_left_next   = '0;
                        short_left_next  = '0;
                        long_total_next  = '0;
                        short_total_next = '0;
                        base_frames_next = '0;
                        res_first_next   = '0;
                        res_last_next    = 1'b1;
                        if (too_high) begin
                            res_second_next = '0;
                            res_err_next    = 1'b1;
                            state_next      = ST_OUT;
                        end else if (flicker_reg == '0) begin
                            res_second_next = refresh_reg;
                            res_err_next    = 1'b0;
                            state_next      = ST_OUT;
                        end else begin
                            state_next = ST_DIV;
                        end
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    base_frames_next = div_quo;
                    long_total_next  = div_rem;
                    short_total_next = flicker_reg - div_rem;
                    long_left_next   = div_rem;
                    short_left_next  = flicker_reg - div_rem;
                    state_next       = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(draw_reg) * PROD_W'(rate);
                state_next = ST_PICK;
            end
            ST_PICK: begin
                res_err_next = 1'b0;
                if (!base_frames_reg[0]) begin
                    // even frames per period: long periods carry the spare frame
                    if (take_long && (k_long < (long_total_reg >> 1))) begin
                        res_first_next  = half_lo;
                        res_second_next = half_hi;
                    end else if (take_long) begin
                        res_first_next  = half_hi;
                        res_second_next = half_lo;
                    end else begin
                        res_first_next  = half_lo;
                        res_second_next = half_lo;
                    end
                end else begin
                    // odd frames per period: short periods lose one frame
                    if (take_long) begin
                        res_first_next  = half_hi;
                        res_second_next = half_hi;
                    end else if (k_short < (short_total_reg >> 1)) begin
                        res_first_next  = half_lo;
                        res_second_next = half_hi;
                    end else begin
                        res_first_next  = half_hi;
                        res_second_next = half_lo;
                    end
                end
                if (take_long) begin
                    long_left_next = k_long;
                end else begin
                    short_left_next = k_short;
                end
                res_last_next = (take_long ? (k_long == '0) : (long_left_reg == '0))
                             && (take_long ? (short_left_reg == '0) : (k_short == '0));
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and count registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            long_left_reg   <= '0;
            short_left_reg  <= '0;
            long_total_reg  <= '0;
            short_total_reg <= '0;
            base_frames_reg <= '0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            long_left_reg   <= long_left_next;
            short_left_reg  <= short_left_next;
            long_total_reg  <= long_total_next;
            short_total_reg <= short_total_next;
            base_frames_reg <= base_frames_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        draw_reg       <= draw_next;
        prod_reg       <= prod_next;
        res_first_reg  <= res_first_next;
        res_second_reg <= res_second_next;
        res_last_reg   <= res_last_next;
        res_err_reg    <= res_err_next;
        if (state_reg == ST_OUT && out_free) begin
            m_first_reg  <= res_first_reg;
            m_second_reg <= res_second_reg;
            m_last_reg   <= res_last_reg;
            m_err_reg    <= res_err_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_first_half_frames  = m_first_reg;
    assign m_second_half_frames = m_second_reg;
    assign m_last               = m_last_reg;
    assign m_rate_error         = m_err_reg;

endmodule

/* verif/ffs_period_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffs_period_checker
// Watches the flicker frame sequencer and checks every period word it returns.
// ----------------------------------------------------------------------------
// Follows the register writes and each accepted input word. For each accepted
// input word it steps its own model of the period sequence and queues the
// expected period. Each accepted result word is compared field by field with
// the oldest queued period. A result word with nothing queued is a failure.
// ----------------------------------------------------------------------------
module ffs_period_checker
    import ffs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_restart,
    input  logic [DRAW_BITS_DEF-1:0] s_draw,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [FRAMES_W-1:0]      m_first_half_frames,
    input  logic [FRAMES_W-1:0]      m_second_half_frames,
    input  logic                     m_last,
    input  logic                     m_rate_error,
    output int                       fail_count,
    output int                       pending,
    output int                       checked_count
);

    localparam int DRAW_W = DRAW_BITS_DEF;

    typedef struct packed {
        logic [FRAMES_W-1:0] first_half;
        logic [FRAMES_W-1:0] second_half;
        logic                last;
        logic                rate_err;
    } period_t;

    // rate settings as last written
    logic [REFRESH_W-1:0] cur_refresh;
    logic [FLICKER_W-1:0] cur_flicker;

    // sequence state of the model
    logic [FLICKER_W-1:0] longs_to_go;
    logic [FLICKER_W-1:0] shorts_to_go;
    logic [FLICKER_W-1:0] longs_loaded;
    logic [FLICKER_W-1:0] shorts_loaded;
    logic [FRAMES_W-1:0]  period_base;

    period_t period_q[$];

    // steps the sequence by one period and returns its frame counts
    function automatic period_t next_period(input logic restart,
                                            input logic [DRAW_W-1:0] draw);
        period_t             p;
        logic [FRAMES_W-1:0] half;
        logic [FLICKER_W-1:0] idx;
        logic [7:0]          rate;
        logic [DRAW_W+7:0]   lhs;
        logic [DRAW_W+7:0]   rhs;
        logic                take_long;
        p = '0;
        // reload on restart or once the second is used up
        if (restart || (longs_to_go == 0 && shorts_to_go == 0)) begin
            longs_to_go   = '0;
            shorts_to_go  = '0;
            longs_loaded  = '0;
            shorts_loaded = '0;
            period_base   = '0;
            if ({1'b0, cur_flicker} > (cur_refresh >> 1)) begin
                p.last     = 1'b1;
                p.rate_err = 1'b1;
                return p;
            end
            if (cur_flicker == 0) begin
                p.second_half = cur_refresh;
                p.last        = 1'b1;
                return p;
            end
            period_base   = cur_refresh / cur_flicker;
            longs_loaded  = FLICKER_W'(cur_refresh % cur_flicker);
            shorts_loaded = cur_flicker - longs_loaded;
            longs_to_go   = longs_loaded;
            shorts_to_go  = shorts_loaded;
        end

        // long or short period
        rate = {1'b0, longs_loaded} + {1'b0, shorts_loaded};
        lhs  = (DRAW_W + 8)'(draw);
        lhs  = lhs * rate;
        rhs  = {1'b0, longs_loaded, {DRAW_W{1'b0}}};
        if (longs_to_go == 0)
            take_long = 1'b0;
        else if (shorts_to_go == 0)
            take_long = 1'b1;
        else
            take_long = (lhs < rhs);

        // split into halves, odd frame placed by position in the second
        if (!period_base[0]) begin
            half = period_base >> 1;
            if (take_long) begin
                idx = longs_to_go - 1'b1;
                if (idx < (longs_loaded >> 1)) begin
                    p.first_half  = half;
                    p.second_half = half + 1'b1;
                end else begin
                    p.first_half  = half + 1'b1;
                    p.second_half = half;
                end
            end else begin
                p.first_half  = half;
                p.second_half = half;
            end
        end else begin
            half = (period_base >> 1) + 1'b1;
            if (take_long) begin
                p.first_half  = half;
                p.second_half = half;
            end else begin
                idx = shorts_to_go - 1'b1;
                if (idx < (shorts_loaded >> 1)) begin
                    p.first_half  = half - 1'b1;
                    p.second_half = half;
                end else begin
                    p.first_half  = half;
                    p.second_half = half - 1'b1;
                end
            end
        end

        if (take_long)
            longs_to_go = longs_to_go - 1'b1;
        else
            shorts_to_go = shorts_to_go - 1'b1;
        p.last = (longs_to_go == 0 && shorts_to_go == 0);
        return p;
    endfunction

    function automatic void compare_field(input string fname, input int want,
                                          input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, fname, want, got);
            fail_count++;
        end
    endfunction

    // follow writes, check result words, queue predictions
    always @(posedge aclk) begin
        period_t want;
        if (!aresetn) begin
            cur_refresh   = 8'd60;
            cur_flicker   = '0;
            longs_to_go   = '0;
            shorts_to_go  = '0;
            longs_loaded  = '0;
            shorts_loaded = '0;
            period_base   = '0;
            period_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_REFRESH_RATE: cur_refresh = cfg_wdata;
                    REG_FLICKER_RATE: cur_flicker = cfg_wdata[FLICKER_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (period_q.size() == 0) begin
                    $display("%0t: unexpected result word, actual %0d %0d %0d %0d",
                             $time, m_first_half_frames, m_second_half_frames,
                             m_last, m_rate_error);
                    fail_count++;
                end else begin
                    want = period_q.pop_front();
                    compare_field("first_half_frames", want.first_half,
                                  m_first_half_frames);
                    compare_field("second_half_frames", want.second_half,
                                  m_second_half_frames);
                    compare_field("last", want.last, m_last);
                    compare_field("rate_error", want.rate_err, m_rate_error);
                    checked_count++;
                end
            end
            // append the prediction at the tail of the queue
            if (s_valid && s_ready)
                period_q.insert(period_q.size(), next_period(s_restart, s_draw));
        end
        pending <= period_q.size();
    end

endmodule

/* verif/tb_flicker_frame_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flicker_frame_sequencer
// Stimulus and verdict for the flicker frame sequencer.
// ----------------------------------------------------------------------------
// Sets rate pairs between phases, sends period requests with random gaps and
// random result back-pressure, and leaves prediction and comparison to the
// period checker. A directed part covers reset values, steady and zero rates,
// the rate error, both period kinds with both half orders, restart and reload
// on exhaustion; random phases then run partial and whole seconds.
// ----------------------------------------------------------------------------
module tb_flicker_frame_sequencer;
    import ffs_pkg::*;

    localparam int RANDOM_WORDS = 1050;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 32;

    logic                     aclk;
    logic                     aresetn              = 1'b0;
    logic                     cfg_wr_en            = 1'b0;
    logic                     cfg_index            = REG_REFRESH_RATE;
    logic [CFG_W-1:0]         cfg_wdata            = '0;
    logic                     s_valid              = 1'b0;
    logic                     s_ready;
    logic                     s_restart            = 1'b0;
    logic [DRAW_BITS_DEF-1:0] s_draw               = '0;
    logic                     m_valid;
    logic                     m_ready              = 1'b0;
    logic [FRAMES_W-1:0]      m_first_half_frames;
    logic [FRAMES_W-1:0]      m_second_half_frames;
    logic                     m_last;
    logic                     m_rate_error;

    int fail_count;
    int pending;
    int checked_count;
    int idle_max = 6;
    int word_count = 0;
    int setting_count = 0;
    int cycle_cnt;

    flicker_frame_sequencer dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_restart            (s_restart),
        .s_draw               (s_draw),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_first_half_frames  (m_first_half_frames),
        .m_second_half_frames (m_second_half_frames),
        .m_last               (m_last),
        .m_rate_error         (m_rate_error)
    );

    ffs_period_checker checker_i (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_restart            (s_restart),
        .s_draw               (s_draw),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_first_half_frames  (m_first_half_frames),
        .m_second_half_frames (m_second_half_frames),
        .m_last               (m_last),
        .m_rate_error         (m_rate_error),
        .fail_count           (fail_count),
        .pending              (pending),
        .checked_count        (checked_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("flicker_frame_sequencer verification failed");
        $finish;
    end

    // result side back-pressure, one stall draw per word
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = $urandom_range(0, idle_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // one request word, returns at the edge it is taken
    task automatic send_word(input logic restart, input logic [DRAW_BITS_DEF-1:0] draw);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        s_draw    <= draw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        word_count++;
    endtask

    // drop valid and wait for every queued period to come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // write both rate registers once the block is idle
    task automatic set_rates(input logic [CFG_W-1:0] refresh, input logic [CFG_W-1:0] flicker);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_REFRESH_RATE;
        cfg_wdata <= refresh;
        @(posedge aclk);
        cfg_index <= REG_FLICKER_RATE;
        cfg_wdata <= flicker;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    function automatic logic [DRAW_BITS_DEF-1:0] pick_draw();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return DRAW_BITS_DEF'($urandom_range(0, (1 << DRAW_BITS_DEF) - 1));
        endcase
    endfunction

    // stimulus and verdict
    initial begin : stimulus
        int rr;
        int fr;
        int fr_max;
        int n;
        int directed_words;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: steady at 60 frames
        send_word(1'b0, 16'h0000);
        send_word(1'b1, 16'hffff);
        // zero refresh and zero flicker
        set_rates(8'd0, 8'd0);
        send_word(1'b0, 16'h1234);
        // any flicker with zero refresh is too fast
        set_rates(8'd0, 8'd1);
        send_word(1'b0, 16'h0000);
        // just above half the refresh
        set_rates(8'd60, 8'd31);
        send_word(1'b1, 16'h8000);
        // odd base, one long and one short, then reload on exhaustion
        set_rates(8'd7, 8'd2);
        send_word(1'b0, 16'h0000);
        send_word(1'b0, 16'hffff);
        send_word(1'b0, 16'hffff);
        // odd base, shorts in both half orders
        set_rates(8'd10, 8'd3);
        send_word(1'b1, 16'hffff);
        send_word(1'b0, 16'h0000);
        send_word(1'b0, 16'h0000);
        // even base, longs in both half orders, restart mid second
        set_rates(8'd18, 8'd4);
        send_word(1'b1, 16'h0000);
        send_word(1'b1, 16'hffff);
        send_word(1'b0, 16'h0000);
        send_word(1'b0, 16'h0000);
        send_word(1'b0, 16'hffff);
        // widest rates
        set_rates(8'd255, 8'd127);
        send_word(1'b1, 16'h0000);
        send_word(1'b0, 16'hffff);
        send_word(1'b0, 16'h7fff);
        set_rates(8'd255, 8'd1);
        send_word(1'b1, 16'h0000);
        send_word(1'b0, 16'hffff);
        // spare top bit of the flicker write is dropped
        set_rates(8'd255, 8'h80);
        send_word(1'b1, 16'h5555);
        directed_words = word_count;

        // random phases, mostly legal rates and small flicker counts
        while (word_count < directed_words + RANDOM_WORDS) begin
            case ($urandom_range(0, 19))
                0: begin
                    rr = $urandom_range(0, 255);
                    fr = $urandom_range(0, 127);
                end
                1: begin
                    rr = $urandom_range(0, 255);
                    fr = 0;
                end
                default: begin
                    rr = $urandom_range(2, 255);
                    fr_max = (rr / 2 > 127) ? 127 : rr / 2;
                    if ($urandom_range(0, 3) != 0 && fr_max > 12)
                        fr_max = 12;
                    fr = $urandom_range(1, fr_max);
                end
            endcase
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            set_rates(rr[7:0], {1'($urandom_range(0, 1)), fr[6:0]});
            n = $urandom_range(1, 2 * fr + 3);
            repeat (n)
                send_word($urandom_range(0, 31) == 0, pick_draw());
        end

        // drain
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d request words over %0d rate settings, %0d periods checked",
                 word_count, setting_count, checked_count);
        $display("covered steady, zero and too-fast rates, restarts and whole seconds");
        if (fail_count == 0 && pending == 0) begin
            $display("flicker_frame_sequencer verification clean");
        end else begin
            $display("flicker_frame_sequencer verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/ffs_pkg.sv
hdl/ffs_div.sv
hdl/flicker_frame_sequencer.sv
verif/ffs_period_checker.sv
verif/tb_flicker_frame_sequencer.sv
